@@ sv/mfm_pkg.sv @@
`default_nettype none
package mfm_pkg;

	localparam int unsigned SECTORS_PER_TRACK_DEF = 10;
	localparam int unsigned TRACK_BYTES_DEF = 6250;

	localparam int unsigned POS_W = 13;
	localparam int unsigned SEC_W = 4;
	localparam int unsigned OFF_W = 10;
	localparam int unsigned CRC_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 8;

	localparam int unsigned LEAD_GAP_LEN = 32;
	localparam int unsigned SECTOR_LEN = 609;

	localparam logic [BYTE_W-1:0] GAP_BYTE = 8'h4E;
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hA1;
	localparam logic [BYTE_W-1:0] ID_MARK = 8'hFE;
	localparam logic [BYTE_W-1:0] DATA_MARK = 8'hFB;
	localparam logic [BYTE_W-1:0] SIZE_CODE = 8'h02;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 8'd1;

	// CRC-16/CCITT, one byte, MSB first
	function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ sv/mfm_in_if.sv @@
`default_nettype none
interface mfm_in_if;
	logic valid;
	logic ready;
	logic [mfm_pkg::BYTE_W-1:0] payload_byte;

	modport source (output valid, output payload_byte, input ready);
	modport sink (input valid, input payload_byte, output ready);
endinterface
`default_nettype wire

@@ sv/mfm_out_if.sv @@
`default_nettype none
interface mfm_out_if;
	logic valid;
	logic ready;
	logic [mfm_pkg::BYTE_W-1:0] track_byte_out;
	logic took_payload;
	logic end_of_track;

	modport source (output valid, output track_byte_out, output took_payload,
		output end_of_track, input ready);
	modport sink (input valid, input track_byte_out, input took_payload,
		input end_of_track, output ready);
endinterface
`default_nettype wire

@@ sv/mfm_cfg_if.sv @@
`default_nettype none
interface mfm_cfg_if;
	logic valid;
	logic ready;
	logic [mfm_pkg::CFG_IDX_W-1:0] index;
	logic [mfm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/mfm_track_image_formatter.sv @@
`default_nettype none
// Formatted MFM track generator: every item accepted on in_ch yields exactly one
// track byte on out_ch, one item per clock while out_ch is ready, held in an
// output register; no new item is taken while the previous byte waits. The byte
// stream is a 32-byte 0x4E lead gap, SECTORS_PER_TRACK sectors of 609 bytes
// (zeros and syncs, ID field with CRC, gap, zeros and syncs, data field with 512
// payload bytes and CRC, trailing gap) and 0x4E fill up to TRACK_BYTES, then it
// wraps. took_payload marks the items whose payload_byte went into the track;
// on all others the payload is ignored. end_of_track flags the last byte of each
// revolution. Write track_number (index 0) and head_select (index 1) on cfg while
// idle; other indexes are ignored. The CRC-16/CCITT update is one unrolled byte
// step that feeds back into crc_q.
module mfm_track_image_formatter #(
	parameter int unsigned SECTORS_PER_TRACK = mfm_pkg::SECTORS_PER_TRACK_DEF,
	parameter int unsigned TRACK_BYTES = mfm_pkg::TRACK_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mfm_in_if.sink in_ch,
	mfm_out_if.source out_ch,
	mfm_cfg_if.sink cfg
);

	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_FILL = 2'd2;

	localparam logic [mfm_pkg::POS_W-1:0] POS_LAST = mfm_pkg::POS_W'(TRACK_BYTES - 1);
	localparam logic [mfm_pkg::SEC_W-1:0] SEC_COUNT = mfm_pkg::SEC_W'(SECTORS_PER_TRACK);

	logic [mfm_pkg::BYTE_W-1:0] track_q;
	logic head_q;
	logic [mfm_pkg::POS_W-1:0] pos_q;
	logic [mfm_pkg::SEC_W-1:0] sec_q;
	logic [mfm_pkg::OFF_W-1:0] off_q;
	logic [1:0] phase_q;
	logic [mfm_pkg::CRC_W-1:0] crc_q;

	logic out_valid_s1;
	logic [mfm_pkg::BYTE_W-1:0] byte_s1;
	logic take_s1;
	logic last_s1;

	logic accept;
	logic last;
	logic take;
	logic crc_it;
	logic crc_clear;
	logic [mfm_pkg::BYTE_W-1:0] body_b;
	logic [mfm_pkg::BYTE_W-1:0] track_b;
	logic [mfm_pkg::OFF_W:0] off_inc;
	logic [mfm_pkg::SEC_W-1:0] sec_inc;

	assign in_ch.ready = !out_valid_s1 || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	assign off_inc = {1'b0, off_q} + 1'b1;
	assign sec_inc = sec_q + 1'b1;
	assign last = pos_q >= POS_LAST;

	// sector body decode by offset
	always_comb begin
		body_b = mfm_pkg::GAP_BYTE;
		crc_it = 1'b0;
		crc_clear = 1'b0;
		take = 1'b0;
		if (off_q < 10'd12 || (off_q >= 10'd44 && off_q < 10'd56)) begin
			body_b = mfm_pkg::ZERO_BYTE;
			crc_clear = 1'b1;
		end else if ((off_q >= 10'd12 && off_q < 10'd15) ||
			(off_q >= 10'd56 && off_q < 10'd59)) begin
			body_b = mfm_pkg::SYNC_BYTE;
			crc_it = 1'b1;
		end else if (off_q == 10'd15) begin
			body_b = mfm_pkg::ID_MARK;
			crc_it = 1'b1;
		end else if (off_q == 10'd16) begin
			body_b = track_q;
			crc_it = 1'b1;
		end else if (off_q == 10'd17) begin
			body_b = {7'd0, head_q};
			crc_it = 1'b1;
		end else if (off_q == 10'd18) begin
			body_b = {4'd0, sec_inc};
			crc_it = 1'b1;
		end else if (off_q == 10'd19) begin
			body_b = mfm_pkg::SIZE_CODE;
			crc_it = 1'b1;
		end else if (off_q == 10'd20 || off_q == 10'd572) begin
			body_b = crc_q[15:8];
		end else if (off_q == 10'd21 || off_q == 10'd573) begin
			body_b = crc_q[7:0];
		end else if (off_q == 10'd59) begin
			body_b = mfm_pkg::DATA_MARK;
			crc_it = 1'b1;
		end else if (off_q >= 10'd60 && off_q < 10'd572) begin
			body_b = in_ch.payload_byte;
			crc_it = 1'b1;
			take = 1'b1;
		end
	end

	assign track_b = (phase_q == PH_BODY) ? body_b : mfm_pkg::GAP_BYTE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
			head_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mfm_pkg::CFG_TRACK: track_q <= cfg.data;
				mfm_pkg::CFG_HEAD: head_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sec_q <= '0;
			off_q <= '0;
			phase_q <= PH_LEAD;
			crc_q <= mfm_pkg::CRC_INIT;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				sec_q <= '0;
				off_q <= '0;
				phase_q <= PH_LEAD;
				crc_q <= mfm_pkg::CRC_INIT;
			end else begin
				pos_q <= pos_q + 1'b1;
				unique case (phase_q)
					PH_LEAD: begin
						if (off_inc >= (mfm_pkg::OFF_W + 1)'(mfm_pkg::LEAD_GAP_LEN)) begin
							off_q <= '0;
							phase_q <= PH_BODY;
						end else begin
							off_q <= off_inc[mfm_pkg::OFF_W-1:0];
						end
					end
					PH_BODY: begin
						if (crc_clear) begin
							crc_q <= mfm_pkg::CRC_INIT;
						end else if (crc_it) begin
							crc_q <= mfm_pkg::crc16_next(crc_q, body_b);
						end
						if (off_inc >= (mfm_pkg::OFF_W + 1)'(mfm_pkg::SECTOR_LEN)) begin
							off_q <= '0;
							sec_q <= sec_inc;
							if (sec_inc >= SEC_COUNT) begin
								phase_q <= PH_FILL;
							end
						end else begin
							off_q <= off_inc[mfm_pkg::OFF_W-1:0];
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= track_b;
			take_s1 <= take && (phase_q == PH_BODY);
			last_s1 <= last;
		end
	end

	assign out_ch.valid = out_valid_s1;
	assign out_ch.track_byte_out = byte_s1;
	assign out_ch.took_payload = take_s1;
	assign out_ch.end_of_track = last_s1;

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == '0 && phase_q == PH_LEAD && sec_q == '0)
		else $error("state not cleared after end of track");

	a_body_off: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> off_q < mfm_pkg::OFF_W'(mfm_pkg::SECTOR_LEN) && sec_q < SEC_COUNT)
		else $error("sector layout position out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 && !out_ch.ready |-> !accept)
		else $error("item accepted while result is stalled");

	a_take_lead: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> sec_q == '0 && off_q < mfm_pkg::OFF_W'(mfm_pkg::LEAD_GAP_LEN))
		else $error("lead gap state inconsistent");

endmodule
`default_nettype wire
